/* rtl/core/pva_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pva_pkg
// Types and constants shared by the polar vector adder: beat payloads,
// fixed internal widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int MAG_BITS   = 32;
    localparam int ANGLE_BITS = 16;

    // Magnitudes are scaled up so that every input lands at 2^58 full scale
    localparam int GUARD_BITS = 59 - MAG_BITS;
    localparam int DATA_W     = 64;
    localparam int ZW         = 34;
    localparam int TURN_W     = 32;
    localparam int MAX_STAGES = 32;

    localparam logic [TURN_W-1:0] TURN_HALF = 32'h8000_0000;

    localparam logic [ANGLE_BITS-1:0] BEARING_NORTH = '0;
    localparam logic [ANGLE_BITS-1:0] BEARING_EAST  =
        ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] BEARING_SOUTH =
        ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] BEARING_WEST  =
        ANGLE_BITS'(3) << (ANGLE_BITS - 2);

    // atan(2^-i) as a fraction of a turn, scaled by 2^32
    localparam logic [TURN_W-1:0] ATAN_TURN [0:MAX_STAGES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [MAG_BITS-1:0]   first_magnitude;
        logic        [ANGLE_BITS-1:0] first_bearing;
        logic signed [MAG_BITS-1:0]   second_magnitude;
        logic        [ANGLE_BITS-1:0] second_bearing;
    } pva_in_t;

    typedef struct packed {
        logic [MAG_BITS-1:0]   sum_magnitude;
        logic [ANGLE_BITS-1:0] sum_bearing;
    } pva_out_t;

    // Special-case bearing decided from the exact component sum
    typedef struct packed {
        logic                  is_zero;
        logic                  on_axis;
        logic [ANGLE_BITS-1:0] axis_bearing;
    } pva_axis_t;

endpackage

/* rtl/core/polar_vector_add_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_vector_add_top
// Adds two vectors given as Q16.16 magnitude and binary-angle bearing and
// returns the sum as saturated magnitude and bearing.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle while the pipeline is not stalled. Each
// result is presented on m_data, registered, after its item passes
// 2*CORDIC_STAGES+5 registers:
// - an input register;
// - a rotation chain with one register per iteration, resolving both
//   vectors side by side;
// - a register for the component sum;
// - a register for the half-plane fold;
// - a vectoring chain with one register per iteration;
// - a two-stage gain correction built from two 32x32 multipliers.
// The whole pipeline holds while a finished result waits on m_ready.
module polar_vector_add_top
    import pva_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pva_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pva_out_t m_data
);

    localparam int N     = CORDIC_STAGES;
    localparam int DEPTH = 2 * N + 5;

    function automatic logic [32:0] gain_comp(input int stages);
        logic [32:0] c;
        logic [32:0] q;
        logic [63:0] d;
        logic [63:0] rem;
        c = 33'h1_0000_0000;
        for (int i = 0; i < stages && i < MAX_STAGES; i++) begin
            d   = (64'd1 << (2 * i)) + 64'd1;
            rem = '0;
            q   = '0;
            for (int b = 32; b >= 0; b--) begin
                rem = {rem[62:0], c[b]};
                if (rem >= d) begin
                    rem  = rem - d;
                    q[b] = 1'b1;
                end
            end
            c = c - q;
        end
        return c;
    endfunction

    localparam logic [32:0]       GAIN_FULL = gain_comp(CORDIC_STAGES);
    localparam logic [31:0]       GAIN      = GAIN_FULL[31:0];
    localparam logic [DATA_W-1:0] MAG_ROUND = DATA_W'(1) << (GUARD_BITS - 1);
    localparam logic [TURN_W:0]   BRG_ROUND = (TURN_W + 1)'(1) << (TURN_W - 1 - ANGLE_BITS);
    localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

    logic advance;
    logic [DEPTH-1:0] valid_reg;

    // Rotation chain, both vectors in parallel
    logic signed [DATA_W-1:0] rot_x_reg  [0:N][0:1];
    logic signed [DATA_W-1:0] rot_x_next [0:N][0:1];
    logic signed [DATA_W-1:0] rot_y_reg  [0:N][0:1];
    logic signed [DATA_W-1:0] rot_y_next [0:N][0:1];
    logic signed [ZW-1:0]     rot_z_reg  [0:N-1][0:1];
    logic signed [ZW-1:0]     rot_z_next [0:N-1][0:1];

    logic signed [DATA_W-1:0] sum_u_reg, sum_u_next;
    logic signed [DATA_W-1:0] sum_v_reg, sum_v_next;

    // Vectoring chain
    logic signed [DATA_W-1:0] vec_u_reg    [0:N];
    logic signed [DATA_W-1:0] vec_u_next   [0:N];
    logic signed [DATA_W-1:0] vec_v_reg    [0:N];
    logic signed [DATA_W-1:0] vec_v_next   [0:N];
    logic        [TURN_W-1:0] vec_acc_reg  [0:N];
    logic        [TURN_W-1:0] vec_acc_next [0:N];
    pva_axis_t                vec_axis_reg [0:N];
    pva_axis_t                vec_axis_next[0:N];

    logic [DATA_W-1:0]     mul_hi_reg, mul_hi_next;
    logic [DATA_W-1:0]     mul_lo_reg, mul_lo_next;
    logic [ANGLE_BITS-1:0] mul_brg_reg, mul_brg_next;
    pva_axis_t             mul_axis_reg, mul_axis_next;

    pva_out_t out_reg, out_next;

    assign advance = !valid_reg[DEPTH-1] || m_ready;
    assign s_ready = advance;
    assign m_valid = valid_reg[DEPTH-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_valid};
        end
    end

    // Resolve each vector into north and east components
    always_comb begin
        logic signed [MAG_BITS-1:0]   mag_in  [0:1];
        logic        [ANGLE_BITS-1:0] bear_in [0:1];
        logic signed [DATA_W-1:0]     m_scaled;
        logic        [TURN_W-1:0]     t;
        mag_in[0]  = s_data.first_magnitude;
        mag_in[1]  = s_data.second_magnitude;
        bear_in[0] = s_data.first_bearing;
        bear_in[1] = s_data.second_bearing;
        for (int j = 0; j < 2; j++) begin
            m_scaled = DATA_W'(mag_in[j]) <<< GUARD_BITS;
            t = {bear_in[j], {(TURN_W - ANGLE_BITS){1'b0}}};
            // Fold the second and third quadrants by half a turn
            if (t[TURN_W-1] ^ t[TURN_W-2]) begin
                m_scaled      = -m_scaled;
                t[TURN_W-1]   = ~t[TURN_W-1];
            end
            rot_x_next[0][j] = m_scaled;
            rot_y_next[0][j] = '0;
            rot_z_next[0][j] = $signed({{(ZW - TURN_W){t[TURN_W-1]}}, t});
        end
        for (int k = 1; k <= N; k++) begin
            for (int j = 0; j < 2; j++) begin
                if (!rot_z_reg[k-1][j][ZW-1]) begin
                    rot_x_next[k][j] = rot_x_reg[k-1][j] - (rot_y_reg[k-1][j] >>> (k - 1));
                    rot_y_next[k][j] = rot_y_reg[k-1][j] + (rot_x_reg[k-1][j] >>> (k - 1));
                end else begin
                    rot_x_next[k][j] = rot_x_reg[k-1][j] + (rot_y_reg[k-1][j] >>> (k - 1));
                    rot_y_next[k][j] = rot_y_reg[k-1][j] - (rot_x_reg[k-1][j] >>> (k - 1));
                end
            end
        end
        for (int k = 1; k < N; k++) begin
            for (int j = 0; j < 2; j++) begin
                if (!rot_z_reg[k-1][j][ZW-1]) begin
                    rot_z_next[k][j] = rot_z_reg[k-1][j]
                                     - $signed({{(ZW - TURN_W){1'b0}}, ATAN_TURN[k-1]});
                end else begin
                    rot_z_next[k][j] = rot_z_reg[k-1][j]
                                     + $signed({{(ZW - TURN_W){1'b0}}, ATAN_TURN[k-1]});
                end
            end
        end
    end

    assign sum_u_next = rot_x_reg[N][0] + rot_x_reg[N][1];
    assign sum_v_next = rot_y_reg[N][0] + rot_y_reg[N][1];

    // Turn the component sum back into magnitude and bearing
    always_comb begin
        logic u_zero;
        logic v_zero;
        u_zero = (sum_u_reg == '0);
        v_zero = (sum_v_reg == '0);
        vec_axis_next[0].is_zero = u_zero && v_zero;
        vec_axis_next[0].on_axis = u_zero || v_zero;
        if (v_zero) begin
            vec_axis_next[0].axis_bearing = sum_u_reg[DATA_W-1] ? BEARING_SOUTH : BEARING_NORTH;
        end else begin
            vec_axis_next[0].axis_bearing = sum_v_reg[DATA_W-1] ? BEARING_WEST : BEARING_EAST;
        end
        // Bring a southward sum into the right half plane
        if (sum_u_reg[DATA_W-1]) begin
            vec_u_next[0]   = -sum_u_reg;
            vec_v_next[0]   = -sum_v_reg;
            vec_acc_next[0] = TURN_HALF;
        end else begin
            vec_u_next[0]   = sum_u_reg;
            vec_v_next[0]   = sum_v_reg;
            vec_acc_next[0] = '0;
        end
        for (int k = 1; k <= N; k++) begin
            vec_axis_next[k] = vec_axis_reg[k-1];
            if (!vec_v_reg[k-1][DATA_W-1]) begin
                vec_u_next[k]   = vec_u_reg[k-1] + (vec_v_reg[k-1] >>> (k - 1));
                vec_v_next[k]   = vec_v_reg[k-1] - (vec_u_reg[k-1] >>> (k - 1));
                vec_acc_next[k] = vec_acc_reg[k-1] + ATAN_TURN[k-1];
            end else begin
                vec_u_next[k]   = vec_u_reg[k-1] - (vec_v_reg[k-1] >>> (k - 1));
                vec_v_next[k]   = vec_v_reg[k-1] + (vec_u_reg[k-1] >>> (k - 1));
                vec_acc_next[k] = vec_acc_reg[k-1] - ATAN_TURN[k-1];
            end
        end
    end

    // Gain correction: split the magnitude into two 32-bit halves
    always_comb begin
        logic [DATA_W-1:0] u_pos;
        logic [TURN_W:0]   brg_sum;
        u_pos        = vec_u_reg[N][DATA_W-1] ? '0 : vec_u_reg[N];
        mul_hi_next  = u_pos[63:32] * GAIN;
        mul_lo_next  = u_pos[31:0] * GAIN;
        brg_sum      = {1'b0, vec_acc_reg[N]} + BRG_ROUND;
        mul_brg_next = brg_sum[TURN_W-1:TURN_W-ANGLE_BITS];
        mul_axis_next = vec_axis_reg[N];
    end

    always_comb begin
        logic [DATA_W-1:0] mag_sum;
        logic [DATA_W-1:0] mag_shift;
        mag_sum   = mul_hi_reg + {32'd0, mul_lo_reg[63:32]} + MAG_ROUND;
        mag_shift = mag_sum >> GUARD_BITS;
        if (mul_axis_reg.is_zero) begin
            out_next.sum_magnitude = '0;
        end else if (|mag_shift[DATA_W-1:MAG_BITS]) begin
            out_next.sum_magnitude = MAG_MAX;
        end else begin
            out_next.sum_magnitude = mag_shift[MAG_BITS-1:0];
        end
        if (mul_axis_reg.is_zero) begin
            out_next.sum_bearing = BEARING_NORTH;
        end else if (mul_axis_reg.on_axis) begin
            out_next.sum_bearing = mul_axis_reg.axis_bearing;
        end else begin
            out_next.sum_bearing = mul_brg_reg;
        end
    end

    // Payload stages: hold on stall, advance together with the valid bits
    always_ff @(posedge aclk) begin
        if (advance) begin
            rot_x_reg    <= rot_x_next;
            rot_y_reg    <= rot_y_next;
            rot_z_reg    <= rot_z_next;
            sum_u_reg    <= sum_u_next;
            sum_v_reg    <= sum_v_next;
            vec_u_reg    <= vec_u_next;
            vec_v_reg    <= vec_v_next;
            vec_acc_reg  <= vec_acc_next;
            vec_axis_reg <= vec_axis_next;
            mul_hi_reg   <= mul_hi_next;
            mul_lo_reg   <= mul_lo_next;
            mul_brg_reg  <= mul_brg_next;
            mul_axis_reg <= mul_axis_next;
            out_reg      <= out_next;
        end
    end

endmodule
